// ===== src/rm17_pkg.sv =====
// Shared types, constants and functions for the RM(1,7) codec.
`timescale 1ns / 1ps

package rm17_pkg;

    localparam int RM_M   = 7;
    localparam int RM_N   = 128;
    localparam int MSG_W  = 8;
    localparam int HALF_W = 64;
    localparam int LANES  = 8;
    localparam int LANE_N = 16;
    localparam int LIDX_W = 4;
    localparam int LANE_W = 3;
    localparam int VAL_W  = 9;
    localparam int MAG_W  = 8;

    // Pipeline stage numbers
    localparam int ST_X1  = 0;
    localparam int ST_L1  = 3;
    localparam int ST_A1  = 7;
    localparam int ST_M1  = 9;
    localparam int ST_OUT = 10;
    localparam int N_STG  = 11;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef val_t blk_t [LANE_N];
    typedef val_t vec_t [RM_N];

    localparam val_t VAL_P1 = val_t'(1);
    localparam val_t VAL_M1 = val_t'(-1);

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic [RM_M-1:0]  idx;
    } cand_t;

    typedef struct packed {
        logic             action;
        logic [MSG_W-1:0] msg;
    } side_t;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Keep a on ties: a always holds the lower index
    function automatic cand_t pick(cand_t a, cand_t b);
        return (b.mag > a.mag) ? b : a;
    endfunction

    function automatic logic [RM_M-1:0] rev7(logic [RM_M-1:0] v);
        logic [RM_M-1:0] r;
        for (int i = 0; i < RM_M; i++)
        begin
            r[RM_M-1-i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [RM_N-1:0] rm_encode(logic [MSG_W-1:0] msg);
        logic [RM_N-1:0] cw;
        logic [RM_M-1:0] lin;
        logic [RM_M-1:0] jv;
        lin = rev7(msg[RM_M-1:0]);
        for (int j = 0; j < RM_N; j++)
        begin
            jv    = RM_M'(j);
            cw[j] = msg[MSG_W-1] ^ (^(jv & lin));
        end
        return cw;
    endfunction

endpackage

// ===== src/rm17_if.sv =====
// Stream channel interfaces: request (input items) and response (results).
`timescale 1ns / 1ps

interface rm17_in_if;
    import rm17_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [MSG_W-1:0]  message_in;
    logic [HALF_W-1:0] received_low;
    logic [HALF_W-1:0] received_high;

    modport source(output valid, action, message_in, received_low, received_high,
                   input ready);
    modport sink(input valid, action, message_in, received_low, received_high,
                 output ready);
endinterface

interface rm17_out_if;
    import rm17_pkg::*;
    logic              valid;
    logic              ready;
    logic [MSG_W-1:0]  decoded_message;
    logic [HALF_W-1:0] codeword_low;
    logic [HALF_W-1:0] codeword_high;

    modport source(output valid, decoded_message, codeword_low, codeword_high,
                   input ready);
    modport sink(input valid, decoded_message, codeword_low, codeword_high,
                 output ready);
endinterface

// ===== src/rm17_xform.sv =====
// Cross-lane Walsh-Hadamard stages (index bits 4..6), one register per stage.
`timescale 1ns / 1ps

module rm17_xform (
    input  logic                      clk,
    input  logic [2:0]                en,
    input  logic [rm17_pkg::RM_N-1:0] rx,
    output rm17_pkg::vec_t            xo
);
    import rm17_pkg::*;

    vec_t s0;
    vec_t x1_reg, x1_next;
    vec_t x2_reg, x2_next;
    vec_t x3_reg, x3_next;

    always_comb
    begin
        for (int j = 0; j < RM_N; j++)
        begin
            s0[j] = rx[j] ? VAL_M1 : VAL_P1;
        end
        for (int j = 0; j < RM_N; j++)
        begin
            if ((j & LANE_N) == 0)
                x1_next[j] = s0[j] + s0[j ^ LANE_N];
            else
                x1_next[j] = s0[j ^ LANE_N] - s0[j];
        end
        for (int j = 0; j < RM_N; j++)
        begin
            if ((j & (2 * LANE_N)) == 0)
                x2_next[j] = x1_reg[j] + x1_reg[j ^ (2 * LANE_N)];
            else
                x2_next[j] = x1_reg[j ^ (2 * LANE_N)] - x1_reg[j];
        end
        for (int j = 0; j < RM_N; j++)
        begin
            if ((j & (4 * LANE_N)) == 0)
                x3_next[j] = x2_reg[j] + x2_reg[j ^ (4 * LANE_N)];
            else
                x3_next[j] = x2_reg[j ^ (4 * LANE_N)] - x2_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            x1_reg <= x1_next;
        if (en[1])
            x2_reg <= x2_next;
        if (en[2])
            x3_reg <= x3_next;
    end

    assign xo = x3_reg;

endmodule

// ===== src/rm17_lane.sv =====
// One lane: 16-point Walsh-Hadamard on its block, then a local peak search.
`timescale 1ns / 1ps

module rm17_lane (
    input  logic                        clk,
    input  logic [5:0]                  en,
    input  logic [rm17_pkg::LANE_W-1:0] lane_id,
    input  rm17_pkg::blk_t              blk_in,
    output rm17_pkg::cand_t             best
);
    import rm17_pkg::*;

    blk_t  s_in   [LIDX_W];
    blk_t  s_reg  [LIDX_W];
    blk_t  s_next [LIDX_W];
    cand_t leaf   [LANE_N];
    cand_t a1_reg [4];
    cand_t a1_next[4];
    cand_t a2_reg, a2_next;
    val_t  t_abs;

    always_comb
    begin
        s_in[0] = blk_in;
        for (int k = 1; k < LIDX_W; k++)
        begin
            s_in[k] = s_reg[k-1];
        end
        for (int k = 0; k < LIDX_W; k++)
        begin
            for (int i = 0; i < LANE_N; i++)
            begin
                if ((i & (1 << k)) == 0)
                    s_next[k][i] = s_in[k][i] + s_in[k][i ^ (1 << k)];
                else
                    s_next[k][i] = s_in[k][i ^ (1 << k)] - s_in[k][i];
            end
        end

        // Leaves: magnitude, sign and global index of each spectrum value
        t_abs = '0;
        for (int i = 0; i < LANE_N; i++)
        begin
            t_abs        = s_reg[LIDX_W-1][i][VAL_W-1] ? -s_reg[LIDX_W-1][i]
                                                       : s_reg[LIDX_W-1][i];
            leaf[i].mag  = t_abs[MAG_W-1:0];
            leaf[i].neg  = !(s_reg[LIDX_W-1][i] > 0);
            leaf[i].idx  = {lane_id, LIDX_W'(i)};
        end

        for (int g = 0; g < 4; g++)
        begin
            a1_next[g] = pick(pick(pick(leaf[4*g], leaf[4*g+1]), leaf[4*g+2]),
                              leaf[4*g+3]);
        end
        a2_next = pick(pick(pick(a1_reg[0], a1_reg[1]), a1_reg[2]), a1_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LIDX_W; k++)
        begin
            if (en[k])
                s_reg[k] <= s_next[k];
        end
        if (en[4])
            a1_reg <= a1_next;
        if (en[5])
            a2_reg <= a2_next;
    end

    assign best = a2_reg;

endmodule

// ===== src/rm17_merge.sv =====
// Merges the lane peaks and forms the result register (decode or encode).
`timescale 1ns / 1ps

module rm17_merge (
    input  logic                      clk,
    input  logic [1:0]                en,
    input  rm17_pkg::cand_t           lane_best [rm17_pkg::LANES],
    input  rm17_pkg::side_t           side,
    output logic [rm17_pkg::MSG_W-1:0] decoded,
    output logic [rm17_pkg::RM_N-1:0]  codeword
);
    import rm17_pkg::*;

    cand_t            m1_reg [2];
    cand_t            m1_next[2];
    cand_t            fin;
    logic [MSG_W-1:0] dec_reg, dec_next;
    logic [RM_N-1:0]  cw_reg, cw_next;

    always_comb
    begin
        m1_next[0] = pick(pick(pick(lane_best[0], lane_best[1]), lane_best[2]),
                          lane_best[3]);
        m1_next[1] = pick(pick(pick(lane_best[4], lane_best[5]), lane_best[6]),
                          lane_best[7]);
        fin        = pick(m1_reg[0], m1_reg[1]);
        if (side.action == ACT_DECODE)
        begin
            dec_next = {fin.neg, rev7(fin.idx)};
            cw_next  = '0;
        end
        else
        begin
            dec_next = '0;
            cw_next  = rm_encode(side.msg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            m1_reg <= m1_next;
        if (en[1])
        begin
            dec_reg <= dec_next;
            cw_reg  <= cw_next;
        end
    end

    assign decoded  = dec_reg;
    assign codeword = cw_reg;

endmodule

// ===== src/reed_muller_1_7_codec_unit.sv =====
// Top level of the RM(1,7) encoder / Hadamard decoder pipeline.
//
//  channel   dir  payload                                         transaction
//  in_ch     in   action, message_in, received_low/high           valid & ready
//  out_ch    out  decoded_message, codeword_low/high              valid & ready
//
// One transaction per cycle sustained while out_ch is not stalled; stages: 3 cross-lane
// transform stages, 4 in-lane stages, 2 peak-search stages, merge, output.
// Each stage has its own valid bit and loads when empty or when the next
// stage moves, so bubbles close up while the output waits.
// rst_n clears only the valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module reed_muller_1_7_codec_unit (
    input  logic              clk,
    input  logic              rst_n,
    rm17_in_if.sink           in_ch,
    rm17_out_if.source        out_ch
);
    import rm17_pkg::*;

    logic [N_STG-1:0] valid_reg, valid_next;
    logic [N_STG-1:0] en;
    side_t            side_reg [ST_OUT];
    vec_t             xo;
    blk_t             lane_in  [LANES];
    cand_t            lane_best[LANES];
    logic [RM_N-1:0]  codeword;
    logic [MSG_W-1:0] decoded;

    always_comb
    begin
        en[N_STG-1] = !valid_reg[N_STG-1] || out_ch.ready;
        for (int s = N_STG - 2; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s+1];
        end
        for (int s = 0; s < N_STG; s++)
        begin
            if (!en[s])
                valid_next[s] = valid_reg[s];
            else if (s == 0)
                valid_next[s] = in_ch.valid;
            else
                valid_next[s] = valid_reg[(s == 0) ? 0 : s - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Sideband (mode and message) follows the item down the pipe
    always_ff @(posedge clk)
    begin
        if (en[0])
            side_reg[0] <= '{action: in_ch.action, msg: in_ch.message_in};
        for (int s = 1; s < ST_OUT; s++)
        begin
            if (en[s])
                side_reg[s] <= side_reg[s-1];
        end
    end

    rm17_xform u_xform (
        .clk (clk),
        .en  (en[ST_X1+2:ST_X1]),
        .rx  ({in_ch.received_high, in_ch.received_low}),
        .xo  (xo)
    );

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            for (int i = 0; i < LANE_N; i++)
            begin
                lane_in[k][i] = xo[k * LANE_N + i];
            end
        end
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        rm17_lane u_lane (
            .clk     (clk),
            .en      (en[ST_A1+1:ST_L1]),
            .lane_id (LANE_W'(k)),
            .blk_in  (lane_in[k]),
            .best    (lane_best[k])
        );
    end

    rm17_merge u_merge (
        .clk       (clk),
        .en        (en[ST_OUT:ST_M1]),
        .lane_best (lane_best),
        .side      (side_reg[ST_OUT-1]),
        .decoded   (decoded),
        .codeword  (codeword)
    );

    assign in_ch.ready            = en[0];
    assign out_ch.valid           = valid_reg[N_STG-1];
    assign out_ch.decoded_message = decoded;
    assign out_ch.codeword_low    = codeword[HALF_W-1:0];
    assign out_ch.codeword_high   = codeword[RM_N-1:HALF_W];

endmodule

// ===== src/rm17_chk.sv =====
// Port-level assertions for the codec, bound to the top level.
`timescale 1ns / 1ps

module rm17_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  decoded,
    input logic [63:0] cw_low,
    input logic [63:0] cw_high
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(decoded)
            && $stable(cw_low) && $stable(cw_high))
        else $error("result changed while stalled");

    // Pipeline never stalls the input unless the output is blocked
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled with output free");

    // Only one mode's fields may be nonzero
    a_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (decoded == 8'd0) || (cw_low == 64'd0 && cw_high == 64'd0))
        else $error("both decode and encode fields nonzero");

    // Upper half of a codeword is the lower half, possibly complemented
    a_cw_halves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cw_high == cw_low) || (cw_high == ~cw_low))
        else $error("codeword halves inconsistent");

endmodule

bind reed_muller_1_7_codec_unit rm17_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .decoded   (out_ch.decoded_message),
    .cw_low    (out_ch.codeword_low),
    .cw_high   (out_ch.codeword_high)
);
